@@ rtl/tox_pkg.sv @@
// ----------------------------------------------------------------------------
// tox_pkg
// Shared types and constants of the terminal output expander.
// ----------------------------------------------------------------------------
package tox_pkg;

   localparam int CHAR_W = 8;
   localparam int COL_W  = 16;
   localparam int MAX_OUT = 8;
   localparam int CNT_W  = $clog2(MAX_OUT + 1);
   localparam int COL_MAX_VAL = (1 << COL_W) - 1;
   localparam logic [COL_W-1:0] COL_MAX = COL_W'(COL_MAX_VAL);

   // Control characters
   localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // Register map
   typedef enum logic [0:0] {
      CSR_MAP_NEWLINE = 1'b0,
      CSR_EXPAND_TABS = 1'b1
   } csr_index_type;

   // Controller to datapath
   typedef struct packed {
      logic load;   // latch the accepted item and update the column
      logic push;   // move the next byte into the output register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic slot_free;  // output register empty or being taken
      logic last;       // the byte to push is the final one of the item
   } status_type;

endpackage

@@ rtl/tox_ctrl.sv @@
// ----------------------------------------------------------------------------
// tox_ctrl
// Sequencer: accepts one item, then steps its bytes into the output register.
// ----------------------------------------------------------------------------
module tox_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output tox_pkg::cmd_type    cmd,
   input  tox_pkg::status_type status
);
   import tox_pkg::*;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   // Decode commands
   always_comb begin
      cmd.load = req_tvalid && ready_ff;
      cmd.push = (state_ff == ST_EMIT) && status.slot_free;
   end

   assign req_tready = ready_ff;

   // Hold state and ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_EMIT;
                  ready_ff <= 1'b0;
               end
            end
            ST_EMIT: begin
               if (cmd.push && status.last) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

@@ rtl/tox_datapath.sv @@
// ----------------------------------------------------------------------------
// tox_datapath
// Column tracking, byte sequence registers, settings and output register.
// ----------------------------------------------------------------------------
module tox_datapath #(
   parameter int TAB_WIDTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  tox_pkg::csr_index_type      csr_index,
   input  logic                        csr_wdata,
   input  logic [tox_pkg::CHAR_W-1:0]  char_in,
   input  tox_pkg::cmd_type            cmd,
   output tox_pkg::status_type         status,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tox_pkg::CHAR_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast
);
   import tox_pkg::*;

   localparam int PW = $clog2(TAB_WIDTH);
   localparam int DW = $clog2(TAB_WIDTH + 1);
   localparam logic [PW-1:0] PHASE_TOP = PW'(TAB_WIDTH - 1);
   localparam logic [PW-1:0] SAT_PHASE = PW'(COL_MAX_VAL % TAB_WIDTH);

   logic             map_newline_ff;
   logic             expand_tabs_ff;
   logic [COL_W-1:0] column_ff, column_in;
   logic [PW-1:0]    phase_ff, phase_in;      // column modulo TAB_WIDTH
   logic [CHAR_W-1:0] ch_first_ff, ch_first_in;
   logic [CHAR_W-1:0] ch_rest_ff, ch_rest_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             first_ff;
   logic             out_valid_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic             out_last_ff;

   logic [DW-1:0]    tab_dist;
   logic [COL_W:0]   tab_sum;
   logic [COL_W-1:0] col_inc;
   logic [PW-1:0]    phase_inc;

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_newline_ff <= 1'b0;
         expand_tabs_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_NEWLINE: map_newline_ff <= csr_wdata;
            CSR_EXPAND_TABS: expand_tabs_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Advance helpers
   always_comb begin
      tab_dist  = DW'(TAB_WIDTH) - DW'(phase_ff);
      tab_sum   = {1'b0, column_ff} + (COL_W + 1)'(tab_dist);
      col_inc   = (column_ff == COL_MAX) ? COL_MAX : column_ff + COL_W'(1);
      phase_inc = (column_ff == COL_MAX) ? phase_ff :
                  (phase_ff == PHASE_TOP) ? '0 : phase_ff + PW'(1);
   end

   // Decode the accepted character
   always_comb begin
      column_in   = column_ff;
      phase_in    = phase_ff;
      ch_first_in = char_in;
      ch_rest_in  = char_in;
      remain_in   = CNT_W'(1);
      case (char_in)
         CH_BS: begin
            if (column_ff != '0) begin
               column_in = column_ff - COL_W'(1);
               phase_in  = (phase_ff == '0) ? PHASE_TOP : phase_ff - PW'(1);
            end
         end
         CH_CR: begin
            column_in = '0;
            phase_in  = '0;
         end
         CH_LF: begin
            if (map_newline_ff) begin
               ch_first_in = CH_CR;
               remain_in   = CNT_W'(2);
               column_in   = '0;
               phase_in    = '0;
            end else begin
               column_in = col_inc;
               phase_in  = phase_inc;
            end
         end
         CH_TAB: begin
            if (expand_tabs_ff) begin
               ch_first_in = CH_SPACE;
               ch_rest_in  = CH_SPACE;
               remain_in   = (32'(tab_dist) > 32'(MAX_OUT)) ? CNT_W'(MAX_OUT) :
                             CNT_W'(tab_dist);
            end
            if (tab_sum > (COL_W + 1)'(COL_MAX_VAL)) begin
               column_in = COL_MAX;
               phase_in  = SAT_PHASE;
            end else begin
               column_in = tab_sum[COL_W-1:0];
               phase_in  = '0;
            end
         end
         default: begin
            column_in = col_inc;
            phase_in  = phase_inc;
         end
      endcase
   end

   // Column state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         phase_ff  <= '0;
      end else if (cmd.load) begin
         column_ff <= column_in;
         phase_ff  <= phase_in;
      end
   end

   // Byte sequence: load on accept, count down per pushed byte
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_first_ff <= ch_first_in;
         ch_rest_ff  <= ch_rest_in;
         remain_ff   <= remain_in;
         first_ff    <= 1'b1;
      end else if (cmd.push) begin
         remain_ff <= remain_ff - CNT_W'(1);
         first_ff  <= 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_char_ff <= first_ff ? ch_first_ff : ch_rest_ff;
         out_last_ff <= (remain_ff == CNT_W'(1));
      end
   end

   always_comb begin
      status.slot_free = !out_valid_ff || rsp_tready;
      status.last      = (remain_ff == CNT_W'(1));
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ rtl/tty_output_expander.sv @@
// ----------------------------------------------------------------------------
// tty_output_expander
// Terminal output post-processor: tab expansion and newline mapping.
// ----------------------------------------------------------------------------
// Usage:
//   req_ stream carries one raw character per item. rsp_ stream carries the
//   bytes to send, one per item, with tlast on the final byte caused by each
//   input character. The csr_ port sets map_newline (index 0) and
//   expand_tabs (index 1); write it only while the block is idle.
//   An input character is accepted first, and the single byte sequencer
//   then pushes its output bytes into the output register one by one
//   (one for plain characters, two for a mapped line feed, up to eight for
//   an expanded tab), each waiting while the output register holds a byte.
//   req_tready drops after an accept and rises again as the last byte
//   enters the output register, so the next character is taken while that
//   byte still waits.
//   When the receiver stalls, the output register holds its byte and the
//   sequencer waits. Reset clears the column, both settings, the output
//   register and returns the sequencer to accepting input.
// ----------------------------------------------------------------------------
module tty_output_expander #(
   parameter int TAB_WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  tox_pkg::csr_index_type     csr_index,
   input  logic                       csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tox_pkg::CHAR_W-1:0] req_tdata,   // [7:0] char_in
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [tox_pkg::CHAR_W-1:0] rsp_tdata,   // [7:0] char_out
   output logic                       rsp_tlast
);
   import tox_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer
   tox_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Column and byte datapath
   tox_datapath #(
      .TAB_WIDTH (TAB_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .char_in    (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/tox_checker.sv @@
// ----------------------------------------------------------------------------
// tox_checker
// Port-level checks of the terminal output expander.
// ----------------------------------------------------------------------------
module tox_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [tox_pkg::CHAR_W-1:0] rsp_tdata,
   input logic                       rsp_tlast
);

   // Take one character at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on two consecutive cycles");

   // Ready input only leaves a final byte pending
   a_ready_last: assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("input ready while a non-final byte is pending");

   // Drop the output after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid right after reset");

   // Hold a stalled output byte
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output byte changed");

endmodule

bind tty_output_expander tox_checker u_tox_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal output expander. A queue of raw
// characters feeds a stream driver; each accepted character is run through a
// local column tracker that predicts the output bytes, and a stream monitor
// compares every output byte and its tlast flag against the oldest
// prediction. Covers reset defaults, all four newline and tab settings,
// column flooring, tab stops at several columns, and random traffic with
// random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tox_pkg::*;

   localparam int TAB_STOP    = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } out_byte_type;

   // DUT connections, all inputs known from time zero
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 csr_we     = 1'b0;
   csr_index_type        csr_index  = CSR_MAP_NEWLINE;
   logic                 csr_wdata  = 1'b0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CHAR_W-1:0]    req_tdata  = '0;   // [7:0] char_in
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CHAR_W-1:0]    rsp_tdata;         // [7:0] char_out
   logic                 rsp_tlast;

   // Bench state
   logic [CHAR_W-1:0]    char_queue[$];
   out_byte_type         out_bytes_due[$];
   int                   chars_queued   = 0;
   int                   chars_taken    = 0;
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;
   int                   req_idle_max   = 0;
   int                   rsp_stall_max  = 0;
   int                   gap_left       = 0;
   int                   stall_left     = 0;
   out_byte_type         due;

   // Predictor copy of settings and column
   logic                 model_map    = 1'b0;
   logic                 model_expand = 1'b0;
   logic [COL_W-1:0]     line_col     = '0;

   tty_output_expander #(.TAB_WIDTH(TAB_STOP)) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Count cycles and stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // Advance the column, saturating at its maximum
   function automatic logic [COL_W-1:0] col_advance(input logic [COL_W-1:0] col,
                                                    input int n);
      int sum;
      sum = int'(col) + n;
      return (sum > COL_MAX_VAL) ? COL_MAX : COL_W'(sum);
   endfunction

   function automatic void push_byte(input logic [CHAR_W-1:0] ch);
      out_byte_type b;
      b.ch   = ch;
      b.last = 1'b0;
      out_bytes_due.push_back(b);
   endfunction

   // Predict the output bytes of one character and update the column
   function automatic void expand_char(input logic [CHAR_W-1:0] c);
      int tab_dist;
      int emit;
      if (c == CH_BS) begin
         push_byte(c);
         if (line_col != '0) line_col = line_col - COL_W'(1);
      end else if (c == CH_CR) begin
         push_byte(c);
         line_col = '0;
      end else if (c == CH_LF) begin
         if (model_map) begin
            push_byte(CH_CR);
            push_byte(CH_LF);
            line_col = '0;
         end else begin
            push_byte(c);
            line_col = col_advance(line_col, 1);
         end
      end else if (c == CH_TAB) begin
         tab_dist = TAB_STOP - (int'(line_col) % TAB_STOP);
         if (model_expand) begin
            emit = (tab_dist > MAX_OUT) ? MAX_OUT : tab_dist;
            for (int i = 0; i < emit; i++) push_byte(CH_SPACE);
         end else begin
            push_byte(c);
         end
         line_col = col_advance(line_col, tab_dist);
      end else begin
         push_byte(c);
         line_col = col_advance(line_col, 1);
      end
      out_bytes_due[$].last = 1'b1;
   endfunction

   // Driver: present queued characters, predict on each accept
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expand_char(req_tdata);
            chars_taken++;
            gap_left = $urandom_range(0, req_idle_max);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (char_queue.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= char_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each output byte against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (out_bytes_due.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h last %b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               due = out_bytes_due.pop_front();
               if (rsp_tdata !== due.ch)
                  report_mismatch($sformatf("char_out %02h, want %02h",
                                            rsp_tdata, due.ch));
               if (rsp_tlast !== due.last)
                  report_mismatch($sformatf("last %b on %02h, want %b",
                                            rsp_tlast, rsp_tdata, due.last));
            end
            stall_left = $urandom_range(0, rsp_stall_max);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send(input logic [CHAR_W-1:0] c);
      char_queue.push_back(c);
      chars_queued++;
   endtask

   // Hold until every character is taken and every byte has come out
   task automatic wait_idle();
      do @(posedge clock);
      while (chars_taken != chars_queued || out_bytes_due.size() != 0);
   endtask

   // Write both settings; call only while idle
   task automatic set_mode(input logic map_nl, input logic exp_tab);
      csr_we    <= 1'b1;
      csr_index <= CSR_MAP_NEWLINE;
      csr_wdata <= map_nl;
      @(posedge clock);
      model_map  = map_nl;
      csr_index <= CSR_EXPAND_TABS;
      csr_wdata <= exp_tab;
      @(posedge clock);
      model_expand = exp_tab;
      csr_we <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] draw_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return CH_TAB;
      if (pick < 35) return CH_LF;
      if (pick < 43) return CH_CR;
      if (pick < 51) return CH_BS;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // Stimulus
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: no mapping, no expansion; backspace at column zero
      req_idle_max  = 2;
      rsp_stall_max = 2;
      send(CH_BS);
      send(8'h00);
      send(8'hFF);
      send(8'h41);
      send(CH_TAB);
      send(CH_BS);
      send(CH_CR);
      send(CH_LF);
      send(CH_TAB);
      send(CH_SPACE);
      wait_idle();

      // Both on: full, partial and single-space tabs, mapped line feed
      set_mode(1'b1, 1'b1);
      send(CH_CR);
      send(CH_TAB);
      send(8'h61);
      send(CH_TAB);
      send(CH_LF);
      for (int i = 0; i < 7; i++) send(CHAR_W'(8'h61 + i));
      send(CH_TAB);
      send(CH_BS);
      send(8'h55);
      send(8'hAA);
      wait_idle();

      set_mode(1'b1, 1'b0);
      send(CH_LF);
      send(CH_TAB);
      wait_idle();
      set_mode(1'b0, 1'b1);
      send(CH_LF);
      send(CH_TAB);
      wait_idle();

      // Walk the column across several tab stops with unexpanded tabs
      set_mode(1'b0, 1'b0);
      req_idle_max  = 0;
      rsp_stall_max = 0;
      send(CH_CR);
      for (int i = 0; i < 4; i++) send(CH_TAB);
      for (int i = 0; i < 6; i++) send(8'h7A);
      send(CH_TAB);
      send(8'h7A);
      send(CH_BS);
      send(CH_LF);
      wait_idle();
      set_mode(1'b0, 1'b1);
      send(CH_TAB);
      send(CH_BS);
      send(CH_BS);
      send(CH_TAB);
      send(8'h7A);
      send(CH_CR);
      wait_idle();

      // Random traffic over random settings, alternating idle-free stretches
      for (int phase = 0; phase < 5; phase++) begin
         set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         req_idle_max  = (phase % 2 == 0) ? 5 : 0;
         rsp_stall_max = (phase % 3 == 1) ? 0 : 5;
         for (int i = 0; i < 20; i++) send(draw_char());
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/tox_pkg.sv
rtl/tox_ctrl.sv
rtl/tox_datapath.sv
rtl/tty_output_expander.sv
rtl/tox_checker.sv
bench/tb_top.sv
